// ----- rtl/lxt_pkg.sv -----
package lxt_pkg;

    // Default saturation bounds for word length and column counting.
    localparam int unsigned DEFAULT_MAX_LENGTH = 255;
    localparam int unsigned DEFAULT_MAX_COLUMN = 65535;

    // Token kinds.
    localparam logic [3:0] KIND_END      = 4'd0;
    localparam logic [3:0] KIND_LPAREN   = 4'd1;
    localparam logic [3:0] KIND_RPAREN   = 4'd2;
    localparam logic [3:0] KIND_IDENT    = 4'd3;
    localparam logic [3:0] KIND_KEYWORD0 = 4'd4;
    localparam logic [3:0] KIND_ERROR    = 4'd12;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Keyword table: XOR XNOR OR NOR AND NAND NOT IMPLY.
    localparam int KW_COUNT = 8;
    localparam int KW_SLOTS = 5;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
        '{8'h58, 8'h4F, 8'h52, 8'h00, 8'h00},
        '{8'h58, 8'h4E, 8'h4F, 8'h52, 8'h00},
        '{8'h4F, 8'h52, 8'h00, 8'h00, 8'h00},
        '{8'h4E, 8'h4F, 8'h52, 8'h00, 8'h00},
        '{8'h41, 8'h4E, 8'h44, 8'h00, 8'h00},
        '{8'h4E, 8'h41, 8'h4E, 8'h44, 8'h00},
        '{8'h4E, 8'h4F, 8'h54, 8'h00, 8'h00},
        '{8'h49, 8'h4D, 8'h50, 8'h4C, 8'h59}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd4, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd5
    };

    // Depth of the result queue; a character may push two tokens at once.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] column;
        logic [7:0]  length;
        logic        last;
    } token_t;

    // Tokens produced by one character, oldest first.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // Keywords whose letter at position pos equals c. pos_ok is false once
    // the position lies beyond the longest keyword.
    function automatic logic [KW_COUNT-1:0] kw_keep(
        input logic       pos_ok,
        input logic [2:0] pos,
        input logic [7:0] c
    );
        logic [KW_COUNT-1:0] keep;
        keep = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (pos_ok && (pos < KW_LEN[k]) && (c == KW_TEXT[k][pos]))
            begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

endpackage

// ----- rtl/lxt_scan.sv -----
module lxt_scan #(
    parameter int unsigned MAX_LENGTH = lxt_pkg::DEFAULT_MAX_LENGTH,
    parameter int unsigned MAX_COLUMN = lxt_pkg::DEFAULT_MAX_COLUMN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    input  logic                room,
    output lxt_pkg::push_t      push
);
    import lxt_pkg::*;

    localparam int LenW = $clog2(MAX_LENGTH + 1);
    localparam int ColW = $clog2(64'(MAX_COLUMN) + 64'd1);

    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_word_reg, in_word_next;
    logic [ColW-1:0]     column_reg, column_next;
    logic [ColW-1:0]     word_start_reg, word_start_next;
    logic [LenW-1:0]     word_length_reg, word_length_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;

    logic                advance;
    logic                is_letter, is_blank;
    logic                pos_ok;
    logic [KW_COUNT-1:0] keep;
    logic [3:0]          word_kind;
    token_t              word_tok, char_tok;
    logic                emit_word, emit_char;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_char_reg <= in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            in_word_reg     <= 1'b0;
            column_reg      <= ColW'(1);
            word_start_reg  <= '0;
            word_length_reg <= '0;
            cand_reg        <= '1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                in_word_reg     <= in_word_next;
                column_reg      <= column_next;
                word_start_reg  <= word_start_next;
                word_length_reg <= word_length_next;
                cand_reg        <= cand_next;
            end
        end
    end

    assign is_letter = ((in_char_reg >= 8'h41) && (in_char_reg <= 8'h5A)) ||
                       ((in_char_reg >= 8'h61) && (in_char_reg <= 8'h7A));
    assign is_blank  = (in_char_reg == CHAR_SPACE) ||
                       ((in_char_reg >= CHAR_TAB) && (in_char_reg <= CHAR_CR));

    // The candidate mask is narrowed at the current word position.
    assign pos_ok = in_word_reg ? (word_length_reg < LenW'(KW_SLOTS)) : 1'b1;
    assign keep   = kw_keep(pos_ok, in_word_reg ? word_length_reg[2:0] : 3'd0,
                            in_char_reg);

    // The lowest keyword still a candidate and of the word's length wins.
    always_comb
    begin
        word_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (word_length_reg == LenW'(KW_LEN[k])))
            begin
                word_kind = KIND_KEYWORD0 + 4'(k);
            end
        end
    end

    always_comb
    begin
        in_word_next     = in_word_reg;
        word_start_next  = word_start_reg;
        word_length_next = word_length_reg;
        cand_next        = cand_reg;
        column_next      = (column_reg < ColW'(MAX_COLUMN)) ? column_reg + ColW'(1)
                                                            : column_reg;
        emit_word        = 1'b0;
        emit_char        = 1'b0;

        word_tok.kind    = word_kind;
        word_tok.column  = 16'(word_start_reg);
        word_tok.length  = 8'(word_length_reg);
        word_tok.last    = 1'b0;

        char_tok.kind    = KIND_ERROR;
        char_tok.column  = 16'(column_reg);
        char_tok.length  = 8'd1;
        char_tok.last    = 1'b1;

        if (in_word_reg && is_letter)
        begin
            cand_next = cand_reg & keep;
            if (word_length_reg < LenW'(MAX_LENGTH))
            begin
                word_length_next = word_length_reg + LenW'(1);
            end
        end
        else
        begin
            emit_word    = in_word_reg;
            in_word_next = 1'b0;
            if (in_char_reg == CHAR_NUL)
            begin
                // End of text: report it and return to the reset state.
                emit_char        = 1'b1;
                char_tok.kind    = KIND_END;
                char_tok.length  = 8'd0;
                column_next      = ColW'(1);
                word_start_next  = '0;
                word_length_next = '0;
                cand_next        = '1;
            end
            else if (is_blank)
            begin
                emit_char = 1'b0;
            end
            else if (in_char_reg == CHAR_LPAREN)
            begin
                emit_char     = 1'b1;
                char_tok.kind = KIND_LPAREN;
            end
            else if (in_char_reg == CHAR_RPAREN)
            begin
                emit_char     = 1'b1;
                char_tok.kind = KIND_RPAREN;
            end
            else if (is_letter)
            begin
                in_word_next     = 1'b1;
                word_start_next  = column_reg;
                word_length_next = LenW'(1);
                cand_next        = keep;
            end
            else
            begin
                emit_char = 1'b1;
            end
        end

        if (!emit_char)
        begin
            word_tok.last = 1'b1;
        end
    end

    always_comb
    begin
        push.count = advance ? (2'(emit_word) + 2'(emit_char)) : 2'd0;
        push.tok0  = emit_word ? word_tok : char_tok;
        push.tok1  = char_tok;
    end

endmodule

// ----- rtl/lxt_queue.sv -----
module lxt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  lxt_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output lxt_pkg::token_t out_tok
);
    import lxt_pkg::*;

    token_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_tok   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for the two tokens that one character may give.
    assign room      = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + QUEUE_PTR_W'(1)] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(pop);
            count_reg  <= count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
        end
    end

endmodule

// ----- rtl/logic_expression_tokenizer.sv -----
// A character accepted into the input register is lexed from there, and its token words are
// written into the result queue, whose head drives the master side; a second word follows the first.
// Throughput: one character per cycle while the result queue drains; the queue has a single
// read port, so a character that closes a word and gives its own token offers its two words in turn.
// Reset (rst_n low, asynchronous) empties the queue and the input register and sets column to 1.
module logic_expression_tokenizer #(
    parameter int unsigned MAX_LENGTH = lxt_pkg::DEFAULT_MAX_LENGTH,
    parameter int unsigned MAX_COLUMN = lxt_pkg::DEFAULT_MAX_COLUMN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] tok_class, [19:4] start_column,
                                   // [27:20] token_length, [31:28] zero
    output logic        m_tlast    // last token word caused by one character
);
    import lxt_pkg::*;

    push_t  push;
    logic   room;
    token_t out_tok;

    // The scanner holds the accepted character in its input register and, from
    // there, updates the lexer state and pushes zero, one or two tokens into
    // the result queue. It stalls only when the queue lacks space for two
    // tokens, which keeps a finished token from blocking new input.
    lxt_scan #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_COLUMN (MAX_COLUMN)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .room     (room),
        .push     (push)
    );

    // The queue is the result register: its head is the word on the master side.
    lxt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {4'b0000, out_tok.length, out_tok.column, out_tok.kind};
    assign m_tlast = out_tok.last;

endmodule

// ----- rtl/lxt_check.sv -----
module lxt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    import lxt_pkg::*;

    // Nothing is offered while reset is applied.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("token word offered during reset");

    // A stalled word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled token word changed");

    // The end token is always the last word of its character and has no length.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] == KIND_END) |-> m_tlast && (m_tdata[27:20] == 8'd0))
        else $error("malformed end token");

    // Parenthesis and error tokens cover exactly one character.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[3:0] == KIND_LPAREN) || (m_tdata[3:0] == KIND_RPAREN) ||
                     (m_tdata[3:0] == KIND_ERROR))
        |-> (m_tdata[27:20] == 8'd1) && m_tlast)
        else $error("single-character token has wrong length");

endmodule

bind logic_expression_tokenizer lxt_check u_check (.*);
